// ===== design/int8_matrix_multiply_8x16x8_defines.svh =====
// ----------------------------------------------------------------------------
// int8_matrix_multiply_8x16x8 assertion macros
// Shared property forms for the matrix multiplier checks.
// ----------------------------------------------------------------------------
`ifndef INT8_MATRIX_MULTIPLY_8X16X8_DEFINES_SVH
`define INT8_MATRIX_MULTIPLY_8X16X8_DEFINES_SVH

// same-cycle implication
`define I8MM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I8MM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i8mm_pkg.sv =====
// ----------------------------------------------------------------------------
// i8mm_pkg
// Types shared by the matrix multiplier controller and its MAC cells.
// ----------------------------------------------------------------------------
package i8mm_pkg;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } feed_ctl_t;

endpackage

// ===== design/int8_matrix_multiply_8x16x8.sv =====
// ----------------------------------------------------------------------------
// int8_matrix_multiply_8x16x8
// Loads A then B as signed bytes, forms C = A x B on a chain of MAC cells
// and streams C out row by row as int8, wrapped or saturated.
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   tdata[7:0] element
// m_axis    out  tdata[7:0] product_element, tlast last_element
// cfg       in   cfg_wr_data saturate_output
//
// Loading takes ROWS*INNER + INNER*COLS byte transfers.
// Each row of C feeds INNER elements of A through the cell chain into the
// result queue, and starts only once the result queue is empty.
// Input is held off while rows are computed; output stalls hold the queue.
// Synchronous reset clears control state; the matrix stores need no clear.
// ----------------------------------------------------------------------------
`include "int8_matrix_multiply_8x16x8_defines.svh"

module int8_matrix_multiply_8x16x8 #(
  parameter int ROWS  = 8,
  parameter int INNER = 16,
  parameter int COLS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] element
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] product_element
  output logic       m_tlast,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import i8mm_pkg::*;

  localparam int LEFT  = ROWS * INNER;
  localparam int AW    = (LEFT > 1) ? $clog2(LEFT) : 1;
  localparam int KW    = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = $clog2(COLS + 1);
  localparam int ACC_W = 16 + $clog2(INNER);

  localparam logic [1:0] S_LOAD_A = 2'd0;
  localparam logic [1:0] S_LOAD_B = 2'd1;
  localparam logic [1:0] S_FEED   = 2'd2;
  localparam logic [1:0] S_WAIT   = 2'd3;

  logic [1:0]      state;
  logic [AW-1:0]   a_ptr;
  logic [KW-1:0]   bk;
  logic [CW-1:0]   bc;
  logic [KW-1:0]   k;
  logic [RW-1:0]   r;
  logic [PW-1:0]   push_cnt;
  logic            saturate;
  logic [7:0]      amem [LEFT];
  logic signed [7:0] feed_a;
  feed_ctl_t       feed_ctl;
  logic [KW-1:0]   feed_k;
  logic            in_xfer;
  logic            load_end;

  feed_ctl_t         ch_ctl [COLS+1];
  logic [KW-1:0]     ch_k   [COLS+1];
  logic signed [7:0] ch_a   [COLS+1];
  logic [COLS-1:0]   done_vec;
  logic signed [ACC_W-1:0] cell_sum [COLS];
  logic signed [ACC_W-1:0] res_sum;
  logic            res_valid;
  logic [7:0]      res_byte;
  logic            res_last;

  logic [8:0]      qmem [COLS];
  logic [CW-1:0]   q_wr;
  logic [CW-1:0]   q_rd;
  logic [PW-1:0]   q_cnt;
  logic            q_pop;

  assign s_tready = (state == S_LOAD_A) || (state == S_LOAD_B);
  assign in_xfer  = s_tvalid && s_tready;
  assign load_end = in_xfer && (state == S_LOAD_B) && (bc == CW'(COLS - 1)) &&
                    (bk == KW'(INNER - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      saturate <= 1'b0;
    end else if (cfg_wr_en) begin
      saturate <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD_A;
      a_ptr    <= '0;
      bk       <= '0;
      bc       <= '0;
      k        <= '0;
      r        <= '0;
      push_cnt <= '0;
      feed_ctl <= '0;
    end else begin
      feed_ctl.valid <= (state == S_FEED);
      feed_ctl.first <= (k == '0);
      feed_ctl.last  <= (k == KW'(INNER - 1));
      if (res_valid) begin
        push_cnt <= push_cnt + PW'(1);
      end
      case (state)
        S_LOAD_A: begin
          if (in_xfer) begin
            if (a_ptr == AW'(LEFT - 1)) begin
              a_ptr <= '0;
              state <= S_LOAD_B;
            end else begin
              a_ptr <= a_ptr + AW'(1);
            end
          end
        end
        S_LOAD_B: begin
          if (in_xfer) begin
            if (bc == CW'(COLS - 1)) begin
              bc <= '0;
              if (bk == KW'(INNER - 1)) begin
                bk       <= '0;
                r        <= '0;
                push_cnt <= PW'(COLS);
                state    <= S_WAIT;
              end else begin
                bk <= bk + KW'(1);
              end
            end else begin
              bc <= bc + CW'(1);
            end
          end
        end
        S_FEED: begin
          a_ptr <= a_ptr + AW'(1);
          if (k == KW'(INNER - 1)) begin
            k     <= '0;
            r     <= r + RW'(1);
            state <= S_WAIT;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_WAIT: begin
          if (push_cnt == PW'(COLS)) begin
            if (r == RW'(ROWS)) begin
              a_ptr <= '0;
              state <= S_LOAD_A;
            end else if (q_cnt == '0) begin
              push_cnt <= '0;
              k        <= '0;
              state    <= S_FEED;
            end
          end
        end
        default: begin
          state <= S_LOAD_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD_A && in_xfer) begin
      amem[a_ptr] <= s_tdata;
    end
    feed_a <= $signed(amem[a_ptr]);
    feed_k <= k;
  end

  assign ch_ctl[0] = feed_ctl;
  assign ch_k[0]   = feed_k;
  assign ch_a[0]   = feed_a;

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    i8mm_cell #(
      .INNER(INNER), .ID(c), .KW(KW), .CW(CW), .ACC_W(ACC_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .in_ctl (ch_ctl[c]),
      .in_k   (ch_k[c]),
      .in_a   (ch_a[c]),
      .wr_en  (state == S_LOAD_B && in_xfer),
      .wr_col (bc),
      .wr_k   (bk),
      .wr_data(s_tdata),
      .out_ctl(ch_ctl[c+1]),
      .out_k  (ch_k[c+1]),
      .out_a  (ch_a[c+1]),
      .done   (done_vec[c]),
      .sum    (cell_sum[c])
    );
  end

  always_comb begin
    res_sum = '0;
    for (int c = 0; c < COLS; c++) begin
      res_sum = res_sum | (cell_sum[c] & {ACC_W{done_vec[c]}});
    end
  end

  assign res_valid = |done_vec;
  assign res_last  = (r == RW'(ROWS)) && (push_cnt == PW'(COLS - 1));

  always_comb begin
    res_byte = res_sum[7:0];
    if (saturate) begin
      if (res_sum > $signed(ACC_W'(127))) begin
        res_byte = 8'h7f;
      end else if (res_sum < -$signed(ACC_W'(128))) begin
        res_byte = 8'h80;
      end
    end
  end

  assign q_pop = (q_cnt != '0) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (res_valid) begin
      qmem[q_wr] <= {res_last, res_byte};
    end
    if (q_pop) begin
      {m_tlast, m_tdata} <= qmem[q_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr     <= '0;
      q_rd     <= '0;
      q_cnt    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid) begin
        q_wr <= (q_wr == CW'(COLS - 1)) ? '0 : q_wr + CW'(1);
      end
      if (q_pop) begin
        q_rd <= (q_rd == CW'(COLS - 1)) ? '0 : q_rd + CW'(1);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      q_cnt <= q_cnt + PW'(res_valid) - PW'(q_pop);
    end
  end

  `I8MM_ASSERT_IMPL(a_one_cell_done, clk, rst, 1'b1, $onehot0(done_vec), "two cells done")
  `I8MM_ASSERT_IMPL(a_queue_bound, clk, rst, 1'b1, q_cnt <= PW'(COLS), "result queue overflow")
  `I8MM_ASSERT_NEXT(a_load_to_wait, clk, rst, load_end, state == S_WAIT, "load end missed")

endmodule

// ===== design/i8mm_cell.sv =====
// ----------------------------------------------------------------------------
// i8mm_cell
// One column of B with a multiply-accumulate; forwards the A feed to the next
// cell in the following cycle.
// ----------------------------------------------------------------------------
module i8mm_cell #(
  parameter int INNER = 16,
  parameter int ID    = 0,
  parameter int KW    = 4,
  parameter int CW    = 3,
  parameter int ACC_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  i8mm_pkg::feed_ctl_t     in_ctl,
  input  logic [KW-1:0]           in_k,
  input  logic signed [7:0]       in_a,
  input  logic                    wr_en,
  input  logic [CW-1:0]           wr_col,
  input  logic [KW-1:0]           wr_k,
  input  logic [7:0]              wr_data,
  output i8mm_pkg::feed_ctl_t     out_ctl,
  output logic [KW-1:0]           out_k,
  output logic signed [7:0]       out_a,
  output logic                    done,
  output logic signed [ACC_W-1:0] sum
);
  import i8mm_pkg::*;

  logic [7:0]         bmem [INNER];
  logic signed [7:0]  bq;
  feed_ctl_t          s1_ctl;
  logic [KW-1:0]      s1_k;
  logic signed [7:0]  s1_a;
  feed_ctl_t          p_ctl;
  logic signed [15:0] prod;

  always_ff @(posedge clk) begin
    if (wr_en && wr_col == CW'(ID)) begin
      bmem[wr_k] <= wr_data;
    end
    if (in_ctl.valid) begin
      bq <= $signed(bmem[in_k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      p_ctl  <= '0;
      done   <= 1'b0;
    end else begin
      s1_ctl <= in_ctl;
      p_ctl  <= s1_ctl;
      done   <= p_ctl.valid && p_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_k <= in_k;
    s1_a <= in_a;
    prod <= s1_a * bq;
    if (p_ctl.valid) begin
      if (p_ctl.first) begin
        sum <= ACC_W'(prod);
      end else begin
        sum <= sum + ACC_W'(prod);
      end
    end
  end

  assign out_ctl = s1_ctl;
  assign out_k   = s1_k;
  assign out_a   = s1_a;

endmodule
